FILE: sv/sha256_hash_engine_defines.svh
// Assertion macros for the SHA-256/224 engine checker.
// No dependencies.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/sha_pkg.sv
// Shared constants and functions for the SHA-256/224 engine.
// No dependencies.
`default_nettype none
package sha_pkg;
    localparam int WordW = 32;
    localparam int TotalW = 61;

    function automatic logic [31:0] iv_word(input logic m224, input logic [2:0] i);
        logic [31:0] r;
        begin
            r = 32'h0;
            if (m224) begin
                unique case (i)
                    3'd0: r = 32'hC1059ED8; 3'd1: r = 32'h367CD507;
                    3'd2: r = 32'h3070DD17; 3'd3: r = 32'hF70E5939;
                    3'd4: r = 32'hFFC00B31; 3'd5: r = 32'h68581511;
                    3'd6: r = 32'h64F98FA7; default: r = 32'hBEFA4FA4;
                endcase
            end else begin
                unique case (i)
                    3'd0: r = 32'h6A09E667; 3'd1: r = 32'hBB67AE85;
                    3'd2: r = 32'h3C6EF372; 3'd3: r = 32'hA54FF53A;
                    3'd4: r = 32'h510E527F; 3'd5: r = 32'h9B05688C;
                    3'd6: r = 32'h1F83D9AB; default: r = 32'h5BE0CD19;
                endcase
            end
            return r;
        end
    endfunction

    localparam logic [31:0] RoundK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };
endpackage
`default_nettype wire

FILE: sv/sha_buf_mem.sv
// Block buffer memory: 16 message words, synchronous write and registered read.
// Depends on sha_pkg.
`default_nettype none
module sha_buf_mem (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic [3:0]              wr_addr,
    input  wire logic [sha_pkg::WordW-1:0] wr_data,
    input  wire logic [3:0]              rd_addr,
    output logic      [sha_pkg::WordW-1:0] rd_data
);
    import sha_pkg::*;
    logic [WordW-1:0] mem [16];
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: sv/sha_compress.sv
// Compression unit: one SHA-256 round per cycle over 64 rounds, message schedule
// kept in a 16-word sliding window, chain add in the top. Depends on sha_pkg.
`default_nettype none
module sha_compress (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [255:0]            chain_in,
    output logic      [3:0]              rd_addr,
    input  wire logic [sha_pkg::WordW-1:0] rd_data,
    output logic      [255:0]            chain_out,
    output logic                         done
);
    import sha_pkg::*;
    typedef enum logic [2:0] {
        C_IDLE = 3'b001, C_LOAD = 3'b010, C_RUN = 3'b100
    } cst_t;

    cst_t        st_reg, st_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] wt, s0, s1, ch, mj, t1, t2;
    logic [31:0] a, e;
    logic        load_word;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign rd_addr = cnt_reg[3:0];
    assign a = v_reg[0];
    assign e = v_reg[4];
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wt = w_reg[0];
    assign ch = v_reg[6] ^ (e & (v_reg[5] ^ v_reg[6]));
    assign mj = (a & v_reg[1]) | (v_reg[2] & (a | v_reg[1]));
    assign t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
              + RoundK[cnt_reg[5:0]] + wt;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
    assign load_word = (st_reg == C_LOAD);
    assign done = done_reg;

    always_comb begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        unique case (st_reg)
            C_IDLE: begin
                cnt_next = 7'd0;
                if (start) begin
                    st_next = C_LOAD;
                    cnt_next = 7'd1;
                end
            end
            C_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16) begin
                    st_next = C_RUN;
                    cnt_next = 7'd0;
                end
            end
            C_RUN: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    st_next = C_IDLE;
                end
            end
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= C_IDLE;
            cnt_reg <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            done_reg <= (st_reg == C_RUN) && (cnt_reg == 7'd63);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == C_IDLE && start) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= chain_in[i*32 +: 32];
            end
        end
        if (load_word) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= rd_data;
        end else if (st_reg == C_RUN) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= s1 + w_reg[9] + s0 + w_reg[0];
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            chain_out[i*32 +: 32] = v_reg[i];
        end
    end
endmodule
`default_nettype wire

FILE: sv/sha256_hash_engine.sv
// SHA-256/SHA-224 engine. A non-final word does not stall input, but the word that
// fills a block stalls it while the block is compressed (16-word buffer read plus
// 64 rounds on one round unit, then chain add). A final word costs one or two block
// compressions plus 8 (or 7) digest transfers. Mode writes restart the message.
`default_nettype none
module sha256_hash_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // message_word[31:0], byte_count[34:32], pad
    input  wire logic        s_tlast,   // final_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], pad
    output logic             m_tlast,   // last_word
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // mode_sha224
);
    import sha_pkg::*;
    typedef enum logic [6:0] {
        S_IN = 7'b0000001, S_CMP = 7'b0000010, S_PADW = 7'b0000100,
        S_ZERO = 7'b0001000, S_LEN = 7'b0010000, S_FCMP = 7'b0100000,
        S_OUT = 7'b1000000
    } st_t;

    st_t          st_reg, st_next;
    logic         mode_reg;
    logic [TotalW-1:0] total_reg, total_next;
    logic [3:0]   pos_reg, pos_next;
    logic [255:0] h_reg;
    logic         start_reg;
    logic         fin2_reg;     // block with length still to come
    logic [2:0]   oidx_reg;
    logic         wr_en;
    logic [3:0]   wr_addr, rd_addr;
    logic [31:0]  wr_data, rd_data;
    logic [255:0] cout;
    logic         cdone;
    logic [31:0]  word, keep;
    logic [2:0]   cnt;
    logic [63:0]  bits;
    logic [255:0] h_sum;
    logic         in_fire;

    assign word = s_tdata[31:0];
    assign cnt = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign in_fire = s_tvalid && s_tready;
    assign s_tready = (st_reg == S_IN);
    assign cfg_ready = (st_reg == S_IN);
    assign bits = {total_reg, 3'b000};

    always_comb begin
        unique case (cnt)
            3'd0: keep = 32'h00000080 << 24;
            3'd1: keep = (word & 32'hFF000000) | 32'h00800000;
            3'd2: keep = (word & 32'hFFFF0000) | 32'h00008000;
            3'd3: keep = (word & 32'hFFFFFF00) | 32'h00000080;
            default: keep = word;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            h_sum[i*32 +: 32] = h_reg[i*32 +: 32] + cout[i*32 +: 32];
        end
    end

    sha_buf_mem u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    sha_compress u_cmp (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg), .chain_in(h_reg),
        .rd_addr(rd_addr), .rd_data(rd_data), .chain_out(cout), .done(cdone)
    );

    always_comb begin
        st_next = st_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg;
        wr_data = 32'h0;
        unique case (st_reg)
            S_IN: begin
                if (in_fire) begin
                    wr_en = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    if (!s_tlast) begin
                        wr_data = word;
                        total_next = total_reg + TotalW'(4);
                        if (pos_reg == 4'd15) begin
                            st_next = S_CMP;
                        end
                    end else begin
                        wr_data = keep;
                        total_next = total_reg + TotalW'(cnt);
                        if (cnt == 3'd4) begin
                            st_next = (pos_reg == 4'd15) ? S_CMP : S_PADW;
                        end else begin
                            st_next = (pos_reg == 4'd15) ? S_FCMP : S_ZERO;
                        end
                    end
                end
            end
            S_CMP: if (cdone) st_next = fin2_reg ? S_PADW : S_IN;
            S_PADW: begin
                wr_en = 1'b1;
                wr_data = 32'h80000000;
                pos_next = pos_reg + 4'd1;
                st_next = (pos_reg == 4'd15) ? S_FCMP : S_ZERO;
            end
            S_ZERO: begin
                if (pos_reg == 4'd14) begin
                    st_next = S_LEN;
                end else begin
                    wr_en = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        st_next = S_FCMP;
                    end
                end
            end
            S_LEN: begin
                wr_en = 1'b1;
                wr_data = pos_reg[0] ? bits[31:0] : bits[63:32];
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'd15) begin
                    st_next = S_FCMP;
                end
            end
            S_FCMP: if (cdone) st_next = fin2_reg ? S_ZERO : S_OUT;
            S_OUT: begin
                if (m_tready && m_tlast) begin
                    st_next = S_IN;
                    total_next = '0;
                    pos_next = 4'd0;
                end
            end
            default: st_next = S_IN;
        endcase
        if (st_reg == S_IN && cfg_valid) begin
            total_next = '0;
            pos_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IN;
            mode_reg <= 1'b0;
            total_reg <= '0;
            pos_reg <= 4'd0;
            start_reg <= 1'b0;
            fin2_reg <= 1'b0;
            oidx_reg <= 3'd0;
            for (int i = 0; i < 8; i++) h_reg[i*32 +: 32] <= iv_word(1'b0, 3'(i));
        end else begin
            st_reg <= st_next;
            total_reg <= total_next;
            pos_reg <= pos_next;
            start_reg <= (st_reg != S_CMP && st_next == S_CMP)
                      || (st_reg != S_FCMP && st_next == S_FCMP);
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
                for (int i = 0; i < 8; i++) h_reg[i*32 +: 32] <= iv_word(cfg_data, 3'(i));
            end
            priority if (in_fire) begin
                fin2_reg <= s_tlast && pos_reg == 4'd15;
            end else if (st_reg == S_CMP && cdone) begin
                fin2_reg <= 1'b0;
            end else if ((st_reg == S_PADW || st_reg == S_ZERO) && pos_reg == 4'd15) begin
                fin2_reg <= 1'b1;
            end else if (st_reg == S_FCMP && cdone) begin
                fin2_reg <= 1'b0;
            end else begin
                fin2_reg <= fin2_reg;
            end
            if (cdone) begin
                h_reg <= h_sum;
            end
            if (st_reg == S_OUT && m_tready) begin
                if (m_tlast) begin
                    oidx_reg <= 3'd0;
                    for (int i = 0; i < 8; i++) h_reg[i*32 +: 32] <= iv_word(mode_reg, 3'(i));
                end else begin
                    oidx_reg <= oidx_reg + 3'd1;
                end
            end
        end
    end

    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata = {5'd0, oidx_reg, h_reg[oidx_reg*32 +: 32]};
    assign m_tlast = mode_reg ? (oidx_reg == 3'd6) : (oidx_reg == 3'd7);
endmodule
`default_nettype wire

FILE: sv/sha_checker.sv
// Port checker for the SHA-256/224 engine, bound to the top level.
// Depends on sha256_hash_engine_defines.svh.
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    `SHA_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input taken during digest")
    `SHA_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1, "digest index skipped")
    `SHA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "digest changed while stalled")
    `SHA_ASSERT_IMPL(a_last, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[34:32] == 3'd6 || m_tdata[34:32] == 3'd7, "bad last index")
endmodule

bind sha256_hash_engine sha_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
